/* rtl/core/hvtb_pkg.sv */
`default_nettype none

package hvtb_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned CNT_W = 21;
  localparam int unsigned BINS  = 256;

  localparam logic [PIX_W-1:0] DIST_RESET = 8'd50;
  localparam logic [PIX_W-1:0] WHITE      = 8'hFF;
  localparam logic [PIX_W-1:0] BLACK      = 8'h00;
  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

  // tuser codes on the slave and master sides
  localparam logic MODE_ACC = 1'b0;
  localparam logic MODE_BIN = 1'b1;
  localparam logic KIND_THR = 1'b0;
  localparam logic KIND_PIX = 1'b1;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [PIX_W-1:0] level_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_PEAK,
    ST_SEC,
    ST_VSTART,
    ST_VAL,
    ST_REPORT
  } state_e;

  typedef enum logic [1:0] {
    PH_PEAK,
    PH_SEC,
    PH_VAL
  } phase_e;

  typedef struct packed {
    logic   acc_en;       // accumulate transfer accepted
    logic   bin_en;       // binarize transfer accepted
    logic   start;        // load scan range and init running registers
    phase_e start_phase;
    phase_e eval_phase;   // pass being evaluated
    logic   clear;        // drop all histogram bins
    logic   report;       // load threshold report into output register
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/hvtb_ctrl.sv */
`default_nettype none

module hvtb_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  input  wire logic            s_mode_i,
  input  wire logic            s_last_i,
  input  wire hvtb_pkg::status_t stat_i,
  output logic                 s_ready_o,
  output hvtb_pkg::cmd_t       cmd_o
);
  import hvtb_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    s_ready_o         = (state_q == ST_IDLE) && stat_i.out_free;
    accept            = s_valid_i && s_ready_o;
    cmd_o.acc_en      = 1'b0;
    cmd_o.bin_en      = 1'b0;
    cmd_o.start       = 1'b0;
    cmd_o.start_phase = PH_PEAK;
    cmd_o.eval_phase  = PH_PEAK;
    cmd_o.clear       = 1'b0;
    cmd_o.report      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.acc_en = accept && (s_mode_i == MODE_ACC);
        cmd_o.bin_en = accept && (s_mode_i == MODE_BIN);
        if (accept && (s_mode_i == MODE_ACC) && s_last_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last bin write lands at the end of this cycle
        cmd_o.start       = 1'b1;
        cmd_o.start_phase = PH_PEAK;
        state_d           = ST_PEAK;
      end
      ST_PEAK: begin
        cmd_o.eval_phase = PH_PEAK;
        if (stat_i.scan_done) begin
          cmd_o.start       = 1'b1;
          cmd_o.start_phase = PH_SEC;
          state_d           = ST_SEC;
        end
      end
      ST_SEC: begin
        cmd_o.eval_phase = PH_SEC;
        if (stat_i.scan_done) begin
          state_d = ST_VSTART;
        end
      end
      ST_VSTART: begin
        cmd_o.start       = 1'b1;
        cmd_o.start_phase = PH_VAL;
        state_d           = ST_VAL;
      end
      ST_VAL: begin
        cmd_o.eval_phase = PH_VAL;
        if (stat_i.scan_done) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (stat_i.out_free) begin
          cmd_o.report = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.acc_en || cmd_o.bin_en) |-> (state_q == ST_IDLE))
    else $error("transfer taken outside idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> $past(cmd_o.acc_en))
    else $error("drain entered without a final accumulate transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.report |=> (state_q == ST_IDLE))
    else $error("report did not return to idle");

endmodule

`default_nettype wire

/* rtl/core/hvtb_datapath.sv */
`default_nettype none

module hvtb_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hvtb_pkg::cmd_t    cmd_i,
  input  wire hvtb_pkg::level_t  pixel_i,
  input  wire logic              cfg_we_i,
  input  wire hvtb_pkg::level_t  cfg_wdata_i,
  input  wire logic              m_ready_i,
  output hvtb_pkg::status_t      stat_o,
  output logic                   m_valid_o,
  output logic                   m_kind_o,
  output hvtb_pkg::level_t       m_thr_o,
  output hvtb_pkg::level_t       m_pix_o
);
  import hvtb_pkg::*;

  // histogram memory, entries qualified by valid bits
  count_t mem_q [BINS];
  logic [BINS-1:0] bin_valid_q;
  count_t rd_q;
  logic   rd_valid_q;
  level_t rd_addr;

  // accumulate stage
  logic   acc_v_q;
  level_t acc_addr_q;
  logic   fwd_q;
  count_t wr_q;
  count_t acc_base;
  count_t acc_inc;

  // scan sequencer
  logic   scan_active_q;
  level_t scan_addr_q;
  level_t scan_end_q;
  logic   eval_v_q;
  logic   eval_last_q;
  level_t eval_idx_q;
  level_t lo, hi;
  level_t lo_q, hi_q;

  // running search registers
  count_t peak_cnt_q, sec_cnt_q, min_cnt_q;
  level_t peak_at_q, sec_at_q, min_at_q;
  count_t cnt;
  level_t gap;
  logic   min_hit;
  level_t min_at_d;
  level_t valley_q;
  level_t min_dist_q;

  // output register
  logic   m_valid_q;
  logic   out_kind_q;
  level_t out_thr_q;
  level_t out_pix_q;
  logic   out_free;

  assign rd_addr  = scan_active_q ? scan_addr_q : pixel_i;
  assign acc_base = fwd_q ? wr_q : (rd_valid_q ? rd_q : '0);
  assign acc_inc  = (acc_base == CNT_MAX) ? acc_base : acc_base + count_t'(1);

  assign cnt = rd_valid_q ? rd_q : '0;
  assign gap = (eval_idx_q > peak_at_q) ? eval_idx_q - peak_at_q : peak_at_q - eval_idx_q;
  assign lo  = (peak_at_q < sec_at_q) ? peak_at_q : sec_at_q;
  assign hi  = (peak_at_q < sec_at_q) ? sec_at_q : peak_at_q;

  assign min_hit  = eval_v_q && (cmd_i.eval_phase == PH_VAL) && (cnt < min_cnt_q);
  assign min_at_d = min_hit ? eval_idx_q : min_at_q;

  assign out_free         = !m_valid_q || m_ready_i;
  assign stat_o.out_free  = out_free;
  assign stat_o.scan_done = eval_v_q && eval_last_q;

  always_ff @(posedge clk_i) begin
    if (acc_v_q) begin
      mem_q[acc_addr_q] <= acc_inc;
    end
    rd_q       <= mem_q[rd_addr];
    rd_valid_q <= bin_valid_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_valid_q   <= '0;
      acc_v_q       <= 1'b0;
      fwd_q         <= 1'b0;
      scan_active_q <= 1'b0;
      eval_v_q      <= 1'b0;
      eval_last_q   <= 1'b0;
      valley_q      <= '0;
      min_dist_q    <= DIST_RESET;
      m_valid_q     <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        bin_valid_q <= '0;
      end else if (acc_v_q) begin
        bin_valid_q[acc_addr_q] <= 1'b1;
      end
      acc_v_q <= cmd_i.acc_en;
      // same bin back to back: memory read missed the write in flight
      fwd_q   <= acc_v_q && cmd_i.acc_en && (acc_addr_q == pixel_i);

      if (cmd_i.start) begin
        scan_active_q <= 1'b1;
      end else if (scan_active_q && (scan_addr_q == scan_end_q)) begin
        scan_active_q <= 1'b0;
      end
      eval_v_q    <= scan_active_q;
      eval_last_q <= scan_active_q && (scan_addr_q == scan_end_q);

      if (eval_v_q && eval_last_q && (cmd_i.eval_phase == PH_VAL)) begin
        valley_q <= min_at_d;
      end
      if (cfg_we_i) begin
        min_dist_q <= cfg_wdata_i;
      end

      if (cmd_i.bin_en || cmd_i.report) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_v_q) begin
      wr_q <= acc_inc;
    end
    acc_addr_q <= pixel_i;
    eval_idx_q <= scan_addr_q;

    if (cmd_i.start) begin
      if (cmd_i.start_phase == PH_VAL) begin
        scan_addr_q <= lo;
        scan_end_q  <= hi;
        lo_q        <= lo;
        hi_q        <= hi;
      end else begin
        scan_addr_q <= '0;
        scan_end_q  <= level_t'(BINS - 1);
      end
    end else if (scan_active_q) begin
      scan_addr_q <= scan_addr_q + level_t'(1);
    end

    if (cmd_i.start && (cmd_i.start_phase == PH_PEAK)) begin
      peak_cnt_q <= '0;
      peak_at_q  <= '0;
    end else if (eval_v_q && (cmd_i.eval_phase == PH_PEAK) && (cnt >= peak_cnt_q)) begin
      peak_cnt_q <= cnt;
      peak_at_q  <= eval_idx_q;
    end

    if (cmd_i.start && (cmd_i.start_phase == PH_SEC)) begin
      sec_cnt_q <= '0;
      sec_at_q  <= '0;
    end else if (eval_v_q && (cmd_i.eval_phase == PH_SEC) && (cnt > sec_cnt_q)
                 && (gap > min_dist_q)) begin
      sec_cnt_q <= cnt;
      sec_at_q  <= eval_idx_q;
    end

    if (cmd_i.start && (cmd_i.start_phase == PH_VAL)) begin
      min_cnt_q <= peak_cnt_q;
      min_at_q  <= '0;
    end else if (min_hit) begin
      min_cnt_q <= cnt;
      min_at_q  <= min_at_d;
    end

    if (cmd_i.bin_en) begin
      out_kind_q <= KIND_PIX;
      out_thr_q  <= valley_q;
      out_pix_q  <= (pixel_i >= valley_q) ? WHITE : BLACK;
    end else if (cmd_i.report) begin
      out_kind_q <= KIND_THR;
      out_thr_q  <= valley_q;
      out_pix_q  <= BLACK;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_kind_o  = out_kind_q;
  assign m_thr_o   = out_thr_q;
  assign m_pix_o   = out_pix_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_active_q |-> !acc_v_q)
    else $error("bin write during a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> scan_active_q)
    else $error("scan did not start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_v_q && eval_last_q && (cmd_i.eval_phase == PH_VAL)) |=>
      ((valley_q == '0) || ((valley_q >= lo_q) && (valley_q <= hi_q))))
    else $error("valley outside the range between the peaks");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (bin_valid_q == '0))
    else $error("histogram not cleared");

endmodule

`default_nettype wire

/* rtl/core/histogram_valley_threshold_binarizer.sv */
// Histogram valley threshold binarizer.
// Slave stream: tdata[7:0] = pixel, tuser = mode (0 accumulate, 1 binarize),
// tlast marks the final pixel of an accumulation pass.
// Master stream: tdata[7:0] = threshold, tdata[15:8] = binarized pixel,
// tuser = kind (0 threshold report, 1 binarized pixel).
// Accumulate pixels are taken one per cycle (read-modify-write into a
// 256 x 21-bit histogram memory with write forwarding) and give no output.
// After the tlast pixel the block stops taking input and scans the
// histogram memory one bin per cycle: a full pass for the peak, a full
// pass for the second peak, then the range between them for the valley.
// The histogram is dropped through its per-bin valid bits at the end of
// the valley scan, then the threshold report loads into the output register.
// Binarize pixels are taken one per cycle; each result sits in the output
// register in the cycle after its transfer. The input stalls while that
// register is full and not being taken on the master side.
// Reset empties the histogram, sets the threshold to 0 and min_peak_distance
// to 50. cfg_we_i writes min_peak_distance from cfg_wdata_i.
`default_nettype none

module histogram_valley_threshold_binarizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  wire logic        s_axis_tuser,   // [0] mode
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] threshold, [15:8] pixel_out
  output logic             m_axis_tuser,   // [0] kind
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i
);
  import hvtb_pkg::*;

  cmd_t    cmd;
  status_t stat;
  level_t  thr;
  level_t  pix;

  hvtb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_mode_i  (s_axis_tuser),
    .s_last_i  (s_axis_tlast),
    .stat_i    (stat),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  hvtb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pixel_i     (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_ready_i   (m_axis_tready),
    .stat_o      (stat),
    .m_valid_o   (m_axis_tvalid),
    .m_kind_o    (m_axis_tuser),
    .m_thr_o     (thr),
    .m_pix_o     (pix)
  );

  assign m_axis_tdata = {pix, thr};

endmodule

`default_nettype wire

/* test/tb.sv */
module tb;
  import hvtb_pkg::*;

  localparam int unsigned PIXEL_TARGET = 1450;
  localparam int unsigned SCAN_SETTLE  = 800;   // worst-case search plus clear
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned IDLE_PCT     = 31;

  typedef struct packed {
    logic   kind;
    level_t threshold;
    level_t pixel_out;
  } pix_result_t;

  class valley_scoreboard;
    count_t      hist[BINS];
    level_t      valley;
    level_t      distance;
    pix_result_t predicted[$];
    int unsigned taken;
    int unsigned errors;

    function new();
      foreach (hist[i]) hist[i] = '0;
      valley   = '0;
      distance = DIST_RESET;
      taken    = 0;
      errors   = 0;
    endfunction

    function void set_distance(level_t d);
      distance = d;
    endfunction

    function void note_pixel(logic mode, level_t pix, logic last);
      int unsigned peak_cnt, sec_cnt, min_cnt, gap;
      int unsigned peak_at, sec_at, lo, hi, min_at;
      taken++;
      if (mode == MODE_BIN) begin
        predicted.push_back('{KIND_PIX, valley, (pix >= valley) ? WHITE : BLACK});
        return;
      end
      if (hist[pix] != CNT_MAX) hist[pix]++;
      if (!last) return;
      // peak: last index holding the largest count
      peak_cnt = 0;
      peak_at  = 0;
      for (int i = 0; i < BINS; i++) begin
        if (hist[i] >= peak_cnt) begin
          peak_cnt = hist[i];
          peak_at  = i;
        end
      end
      // second peak: first strictly largest bin far enough away, else bin 0
      sec_cnt = 0;
      sec_at  = 0;
      for (int i = 0; i < BINS; i++) begin
        gap = (i > peak_at) ? i - peak_at : peak_at - i;
        if (hist[i] > sec_cnt && gap > distance) begin
          sec_cnt = hist[i];
          sec_at  = i;
        end
      end
      lo = (peak_at < sec_at) ? peak_at : sec_at;
      hi = (peak_at < sec_at) ? sec_at : peak_at;
      // valley: running minimum starts at the peak count, level 0
      min_cnt = peak_cnt;
      min_at  = 0;
      for (int i = lo; i <= hi; i++) begin
        if (hist[i] < min_cnt) begin
          min_cnt = hist[i];
          min_at  = i;
        end
      end
      valley = level_t'(min_at);
      foreach (hist[i]) hist[i] = '0;
      predicted.push_back('{KIND_THR, valley, BLACK});
    endfunction

    function void check_result(logic kind, logic [15:0] data);
      pix_result_t want;
      if (predicted.size() == 0) begin
        $error("unexpected result: kind %0d tdata %h", kind, data);
        errors++;
        return;
      end
      want = predicted.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (data[7:0] !== want.threshold) begin
        $error("threshold: expected %0d, got %0d", want.threshold, data[7:0]);
        errors++;
      end
      if (data[15:8] !== want.pixel_out) begin
        $error("pixel_out: expected %0d, got %0d", want.pixel_out, data[15:8]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] pixel
  logic        s_axis_tuser  = 1'b0; // [0] mode
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [7:0] threshold, [15:8] pixel_out
  logic        m_axis_tuser;         // [0] kind
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;

  bit          no_idle       = 1'b0;
  bit          hold_req      = 1'b0;
  int unsigned quiet_cycles  = 0;

  valley_scoreboard sb = new();

  histogram_valley_threshold_binarizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("histogram_valley_threshold_binarizer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random back-pressure, one long hold on request
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_pixel(input logic mode, input level_t pix, input logic last);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= pix;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(mode, pix, last);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.predicted.size() != 0) @(posedge clk_i);
    repeat (SCAN_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_distance(input level_t d);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_distance(d);
  endtask

  // two clusters plus background noise, tlast on the final pixel
  task automatic run_frame(input int unsigned size);
    int          c1, c2, w1, w2, v;
    int unsigned r;
    c1 = $urandom_range(255);
    c2 = $urandom_range(255);
    w1 = $urandom_range(24);
    w2 = $urandom_range(24);
    for (int unsigned k = 0; k < size; k++) begin
      r = $urandom_range(99);
      if (r < 8)       v = $urandom_range(255);
      else if (r < 62) v = c1 + int'($urandom_range(2 * w1)) - w1;
      else             v = c2 + int'($urandom_range(2 * w2)) - w2;
      if (v < 0)        v = 0;
      else if (v > 255) v = 255;
      // stray binarize pixel inside an accumulation pass
      if ($urandom_range(99) < 3)
        send_pixel(MODE_BIN, level_t'($urandom_range(255)), 1'b0);
      send_pixel(MODE_ACC, level_t'(v), k == size - 1);
    end
  endtask

  // binarize pass, biased toward the current threshold
  task automatic binarize_run(input int unsigned n);
    int v;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) < 40) begin
        v = int'(sb.valley) + int'($urandom_range(4)) - 2;
        if (v < 0)        v = 0;
        else if (v > 255) v = 255;
      end else begin
        v = $urandom_range(255);
      end
      send_pixel(MODE_BIN, level_t'(v), 1'($urandom_range(1)));
    end
  endtask

  task automatic random_phase(input int unsigned frames);
    repeat (frames) begin
      run_frame(($urandom_range(11) == 0) ? $urandom_range(150, 400) : $urandom_range(1, 60));
      binarize_run($urandom_range(5, 60));
    end
  endtask

  task automatic directed_items();
    level_t frame_a[8];
    frame_a = '{8'd10, 8'd10, 8'd10, 8'd200, 8'd200, 8'd128, 8'hFF, 8'h00};
    // no threshold yet: everything is white; tlast is ignored here
    send_pixel(MODE_BIN, 8'h00, 1'b0);
    send_pixel(MODE_BIN, 8'hFF, 1'b1);
    foreach (frame_a[i]) send_pixel(MODE_ACC, frame_a[i], i == 7);
    send_pixel(MODE_BIN, 8'h55, 1'b0);
    send_pixel(MODE_BIN, 8'hAA, 1'b0);
    send_pixel(MODE_BIN, sb.valley, 1'b0);
    send_pixel(MODE_BIN, sb.valley - 8'd1, 1'b0);
    // one-pixel frames: peak at the top end, then peak and second peak both at 0
    send_pixel(MODE_ACC, 8'hFF, 1'b1);
    send_pixel(MODE_BIN, 8'h00, 1'b0);
    send_pixel(MODE_ACC, 8'h00, 1'b1);
    send_pixel(MODE_BIN, 8'h01, 1'b0);
  endtask

  initial begin
    level_t d;
    wait (rst_ni);
    @(posedge clk_i);
    directed_items();

    wait_idle();
    write_distance(8'd0);
    random_phase(3);
    wait_idle();
    write_distance(8'd255);
    random_phase(3);

    // back-to-back stretch on both sides
    wait_idle();
    no_idle = 1'b1;
    write_distance(level_t'($urandom_range(255)));
    random_phase(3);
    no_idle = 1'b0;

    // long output stall while binarize pixels keep arriving
    hold_req = 1'b1;
    binarize_run(40);

    while (sb.taken < PIXEL_TARGET) begin
      wait_idle();
      case ($urandom_range(5))
        0:       d = 8'd0;
        1:       d = 8'd255;
        2:       d = 8'd1;
        3:       d = 8'd254;
        default: d = level_t'($urandom_range(8, 120));
      endcase
      write_distance(d);
      random_phase(2);
    end

    wait_idle();
    if (sb.errors == 0 && sb.predicted.size() == 0) begin
      $display("histogram_valley_threshold_binarizer verification clean");
    end else begin
      $display("histogram_valley_threshold_binarizer verification failed");
    end
    $finish;
  end

endmodule
